[design/ilie_pkg.sv]
`default_nettype none

package ilie_pkg;

	localparam int unsigned DEPTH_DEF      = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned CAP_RESET      = 64;
	// entries per first-level read group
	localparam int unsigned GROUP_SIZE     = 8;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic wr_en;
		cmd_t cmd;
	} cell_ctl_t;

endpackage

`default_nettype wire

[design/ilie_ifs.sv]
`default_nettype none

interface ilie_in_if #(
	parameter int unsigned CW = 7,
	parameter int unsigned DW = 32
);
	logic                 valid;
	logic                 ready;
	ilie_pkg::cmd_t       command;
	logic [CW-1:0]        position;
	logic signed [DW-1:0] item_value;

	modport source (output valid, command, position, item_value, input ready);
	modport sink (input valid, command, position, item_value, output ready);
endinterface

interface ilie_out_if #(
	parameter int unsigned CW = 7,
	parameter int unsigned DW = 32
);
	logic                 valid;
	logic                 ready;
	logic                 success;
	logic signed [DW-1:0] read_data;
	logic [CW-1:0]        entry_count;

	modport source (output valid, success, read_data, entry_count, input ready);
	modport sink (input valid, success, read_data, entry_count, output ready);
endinterface

`default_nettype wire

[design/ilie_cell.sv]
`default_nettype none

module ilie_cell #(
	parameter int unsigned CW  = 7,
	parameter int unsigned DW  = 32,
	parameter int unsigned IDX = 0
) (
	input  wire logic                clk,
	input  wire ilie_pkg::cell_ctl_t ctl,
	input  wire logic [CW-1:0]       pos,
	input  wire logic [CW-1:0]       cnt,
	input  wire logic [DW-1:0]       wval,
	input  wire logic [DW-1:0]       left,
	input  wire logic [DW-1:0]       right,
	output logic [DW-1:0]            entry
);
	import ilie_pkg::*;

	localparam logic [CW-1:0] ME = CW'(IDX);

	logic [DW-1:0] entry_q;
	logic [DW-1:0] nxt;

	always_comb begin
		nxt = entry_q;
		case (ctl.cmd)
			CMD_APPEND: begin
				if (ME == cnt) nxt = wval;
			end
			CMD_INSERT: begin
				if (ME == pos) nxt = wval;
				else if (ME > pos) nxt = left;
			end
			CMD_ERASE: begin
				if (ME >= pos) nxt = right;
			end
			default: nxt = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) entry_q <= nxt;
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

[design/ilie_read_sel.sv]
`default_nettype none

// Two-level read select: groups of GROUP_SIZE picked by the low index bits
// into _s1 registers, then the group picked by the high bits.
module ilie_read_sel #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned CW    = 7,
	parameter int unsigned DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [CW-1:0] pos,
	input  wire logic [DW-1:0] cells [DEPTH],
	output logic [DW-1:0]      rdata
);
	import ilie_pkg::*;

	localparam int unsigned NG     = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int unsigned GSEL_W = (NG > 1) ? $clog2(NG) : 1;
	localparam int unsigned LW     = $clog2(GROUP_SIZE);

	logic [DW-1:0]     padded [NG][GROUP_SIZE];
	logic [DW-1:0]     grp_s1 [NG];
	logic [GSEL_W-1:0] hi_s1;
	logic [LW-1:0]     lo;
	logic [GSEL_W-1:0] hi;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_ent
			if (g * GROUP_SIZE + k < DEPTH) begin : g_real
				assign padded[g][k] = cells[g * GROUP_SIZE + k];
			end else begin : g_pad
				assign padded[g][k] = '0;
			end
		end
	end

	assign lo = LW'(pos % GROUP_SIZE);
	assign hi = GSEL_W'(pos / GROUP_SIZE);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NG; g++) begin
				grp_s1[g] <= padded[g][lo];
			end
			hi_s1 <= hi;
		end
	end

	assign rdata = (int'(hi_s1) < NG) ? grp_s1[hi_s1] : '0;

endmodule

`default_nettype wire

[design/indexed_list_insert_erase_top.sv]
// Indexed list with append, insert, erase and read, held in a row of cells.
// req (sink): command, position, item_value; taken when valid and ready are high.
// rsp (source): success, read_data, entry_count; one result per item, in order.
// cap_we / cap_wdata write the capacity limit (reset DEPTH or 64, the lesser);
// the effective limit is the lesser of the register and DEPTH.
// Each cell holds one entry; insert and erase shift every affected cell at once
// from its neighbor in the cycle the item is taken.
// Results pass through the _s1 registers and then the output registers; the _s1
// stage comes from the registered two-level read select over the cells.
// Throughput: one item per cycle while rsp is taken.
// When rsp stalls with a result waiting, req.ready drops and the whole pipe holds.
// Reset clears the count and the pipe valids and loads the capacity register with its
// reset value; entries are undefined until written and only written entries are read.
`default_nettype none

module indexed_list_insert_erase_top #(
	parameter int unsigned DEPTH      = ilie_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ilie_pkg::DATA_WIDTH_DEF,
	parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cap_we,
	input  wire logic [CW-1:0] cap_wdata,
	ilie_in_if.sink            req,
	ilie_out_if.source         rsp
);
	import ilie_pkg::*;

	localparam int unsigned   DW      = DATA_WIDTH;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] CAP_RST = (DEPTH < CAP_RESET) ? CW'(DEPTH) : CW'(CAP_RESET);

	logic [CW-1:0] count_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] lim;
	logic          can_add;
	logic          ok;
	logic [CW-1:0] new_cnt;
	logic          adv;
	logic          accept;
	cell_ctl_t     ctl;

	logic          valid_s1;
	logic          ok_s1;
	logic          rd_s1;
	logic [CW-1:0] cnt_s1;

	logic          out_valid_q;
	logic          success_q;
	logic [DW-1:0] rdata_q;
	logic [CW-1:0] count_out_q;

	logic [DW-1:0] cells [DEPTH];
	logic [DW-1:0] sel_data;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;
	assign accept    = req.valid && adv;

	assign lim     = (cap_q < DEPTH_C) ? cap_q : DEPTH_C;
	assign can_add = count_q < lim;

	always_comb begin
		ok      = 1'b0;
		new_cnt = count_q;
		case (req.command)
			CMD_APPEND: begin
				ok = can_add;
				if (ok) new_cnt = CW'(count_q + 1'b1);
			end
			CMD_INSERT: begin
				ok = can_add && (req.position <= count_q);
				if (ok) new_cnt = CW'(count_q + 1'b1);
			end
			CMD_ERASE: begin
				ok = req.position < count_q;
				if (ok) new_cnt = CW'(count_q - 1'b1);
			end
			CMD_READ: begin
				ok = req.position < count_q;
			end
			default: ok = 1'b0;
		endcase
	end

	assign ctl.wr_en = accept && ok;
	assign ctl.cmd   = req.command;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = cells[i];
		end else begin : g_mid_l
			assign left_d = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cells[i];
		end else begin : g_mid_r
			assign right_d = cells[i+1];
		end
		ilie_cell #(
			.CW  (CW),
			.DW  (DW),
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (req.position),
			.cnt   (count_q),
			.wval  (req.item_value),
			.left  (left_d),
			.right (right_d),
			.entry (cells[i])
		);
	end

	ilie_read_sel #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.DW    (DW)
	) u_read_sel (
		.clk   (clk),
		.en    (adv),
		.pos   (req.position),
		.cells (cells),
		.rdata (sel_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cap_we) cap_q <= cap_wdata;
			if (accept) count_q <= new_cnt;
			if (adv) begin
				valid_s1    <= accept;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1       <= ok;
			rd_s1       <= ok && (req.command == CMD_READ);
			cnt_s1      <= new_cnt;
			success_q   <= ok_s1;
			rdata_q     <= rd_s1 ? sel_data : '0;
			count_out_q <= cnt_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = success_q;
	assign rsp.read_data   = rdata_q;
	assign rsp.entry_count = count_out_q;

endmodule

`default_nettype wire
